// ----- hw/rtl/bba_pkg.sv -----
// Shared types and constants for the buddy block allocator.
// No dependencies; imported by every module of the block.
package bba_pkg;

  localparam int MAX_LEVELS   = 10;
  localparam int MAX_HEAP_LOG = 16;
  localparam int ADDR_W       = MAX_LEVELS;
  localparam int IDX_W        = MAX_LEVELS + 1;
  localparam int LOG_W        = 5;
  localparam int ENTRY_W      = LOG_W + 2;
  localparam int TABLE_DEPTH  = 1 << MAX_LEVELS;

  typedef struct packed {
    logic             head;
    logic             used;
    logic [LOG_W-1:0] lg;
  } entry_t;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [ADDR_W-1:0] addr;
    entry_t            wdata;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_SIZE = 3'd1,
    ST_TOO_BIG   = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_BAD_FREE  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_HEAD,
    S_IDLE,
    S_ARD,
    S_AEV,
    S_SPLIT,
    S_FRD,
    S_FEV,
    S_MCHK,
    S_MEV,
    S_MWR
  } state_t;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;
  localparam logic CFG_HEAP  = 1'b0;
  localparam logic CFG_MIN   = 1'b1;

  // Smallest n with 2^n >= size, for size >= 1.
  function automatic logic [LOG_W-1:0] ceil_log2(input logic [16:0] size);
    logic [16:0]      s1;
    logic [LOG_W-1:0] n;
    s1 = size - 17'd1;
    n  = '0;
    for (int k = 0; k < 17; k++) begin
      if (s1[k]) n = LOG_W'(k + 1);
    end
    return n;
  endfunction

endpackage

// ----- hw/rtl/buddy_block_allocator_unit.sv -----
// Buddy block allocator top level: sequencer plus block table memory.
// Depends on bba_pkg, bba_ctrl and bba_table.
//
// Usage:
//   Requests enter on start/in_* and are taken when start is high and busy
//   is low. in_action selects allocate (size in in_request_size) or free
//   (byte offset in in_block_offset). Each request gives exactly one result,
//   shown for one cycle with out_valid high; the receiver cannot stall it.
//   Size and offset errors answer in the cycle after the request.
//   An allocate reads each table block visited in the scan (up to two
//   passes over at most 1024 slots), then writes one entry per split.
//   A free of a block that is not in use answers after its table read;
//   otherwise the block is rewritten free, and each merge reads the buddy,
//   clears the upper head and writes the merged head. All table accesses go
//   through the single port of the 1024-entry block table.
//   Requests are handled one at a time.
//   Configuration: cfg_index 0 is the heap log, 1 the minimum block log;
//   cfg_ready is always high. Each write starts a clearing pass.
//   Reset and every configuration write run a clearing pass
//   (busy high) that leaves one free block covering the whole heap.
module buddy_block_allocator_unit import bba_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [16:0] in_request_size,
  input  logic [15:0] in_block_offset,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_result_offset,
  output logic [4:0]  out_result_log_size,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);

  mem_req_t mem_req;
  entry_t   mem_rdata;

  bba_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_action           (in_action),
    .in_request_size     (in_request_size),
    .in_block_offset     (in_block_offset),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_result_offset   (out_result_offset),
    .out_result_log_size (out_result_log_size),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .mem_req             (mem_req),
    .mem_rdata           (mem_rdata)
  );

  bba_table u_table (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

// ----- hw/rtl/bba_table.sv -----
// Block table memory: one entry per minimum-size slot, registered read.
// Depends on bba_pkg.
module bba_table import bba_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rdata
);

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) mem[req.addr] <= req.wdata;
  end

  always_ff @(posedge clk) begin
    if (req.re) rdata <= mem[req.addr];
  end

endmodule

// ----- hw/rtl/bba_ctrl.sv -----
// Allocator sequencer: config registers, table clear, scan, split and merge.
// Depends on bba_pkg; drives the bba_table memory port.
module bba_ctrl import bba_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [16:0] in_request_size,
  input  logic [15:0] in_block_offset,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_result_offset,
  output logic [4:0]  out_result_log_size,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  output mem_req_t    mem_req,
  input  entry_t      mem_rdata
);

  state_t            state_r, state_nxt;
  logic [LOG_W-1:0]  heap_r, min_r;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [LOG_W-1:0]  lg_r, lg_nxt;
  logic [LOG_W-1:0]  n_r, n_nxt;
  logic              exact_r, exact_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [15:0]       out_off_r;
  logic [LOG_W-1:0]  out_lg_r;

  logic              fin;
  status_t           fin_status;
  logic [15:0]       fin_off;
  logic [LOG_W-1:0]  fin_lg;

  logic [LOG_W-1:0]  h, m, m0, diff;
  logic [IDX_W-1:0]  cnt, span;
  logic [LOG_W-1:0]  lgm, n_raw, n_fl;
  logic              match;
  logic [16:0]       mask17;
  logic [15:0]       fidx;
  logic [ADDR_W+15:0] off_w;
  logic [ADDR_W-1:0] bud, lo, hi;
  logic              cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign busy      = (state_r != S_IDLE);

  // Effective heap and minimum logs
  always_comb begin
    h    = (heap_r > LOG_W'(MAX_HEAP_LOG)) ? LOG_W'(MAX_HEAP_LOG) : heap_r;
    m0   = (min_r > h) ? h : min_r;
    m    = ((h - m0) > LOG_W'(MAX_LEVELS)) ? (h - LOG_W'(MAX_LEVELS)) : m0;
    diff = h - m;
    cnt  = IDX_W'(1) << diff;
  end

  always_comb begin
    lgm   = mem_rdata.lg - m;
    if (!mem_rdata.head || mem_rdata.lg < m || lgm > LOG_W'(MAX_LEVELS)) begin
      span = IDX_W'(1);
    end else begin
      span = IDX_W'(1) << lgm;
    end
    match = mem_rdata.head && !mem_rdata.used &&
            (exact_r ? (mem_rdata.lg == n_r) : (mem_rdata.lg >= n_r));
    n_raw  = ceil_log2(in_request_size);
    n_fl   = (n_raw < m) ? m : n_raw;
    mask17 = (17'd1 << m) - 17'd1;
    fidx   = in_block_offset >> m;
    off_w  = (ADDR_W + 16)'(idx_r[ADDR_W-1:0]) << m;
    bud    = idx_r[ADDR_W-1:0] ^ (ADDR_W'(1) << (lg_r - m));
    lo     = (idx_r[ADDR_W-1:0] < bud) ? idx_r[ADDR_W-1:0] : bud;
    hi     = (idx_r[ADDR_W-1:0] < bud) ? bud : idx_r[ADDR_W-1:0];
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    lg_nxt     = lg_r;
    n_nxt      = n_r;
    exact_nxt  = exact_r;
    clr_nxt    = clr_r;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_off    = '0;
    fin_lg     = '0;
    mem_req    = '0;

    unique case (state_r)
      S_CLEAR: begin
        mem_req.we   = 1'b1;
        mem_req.addr = clr_r;
        clr_nxt      = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(TABLE_DEPTH - 1)) state_nxt = S_HEAD;
      end
      S_HEAD: begin
        mem_req.we         = 1'b1;
        mem_req.wdata.head = 1'b1;
        mem_req.wdata.lg   = h;
        state_nxt          = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (in_action == ACT_ALLOC) begin
            if (in_request_size == '0) begin
              fin        = 1'b1;
              fin_status = ST_ZERO_SIZE;
            end else if (n_fl > h) begin
              fin        = 1'b1;
              fin_status = ST_TOO_BIG;
            end else begin
              n_nxt     = n_fl;
              idx_nxt   = '0;
              exact_nxt = 1'b1;
              state_nxt = S_ARD;
            end
          end else begin
            if ((|(in_block_offset & mask17[15:0])) || (fidx >= 16'(cnt))) begin
              fin        = 1'b1;
              fin_status = ST_BAD_FREE;
            end else begin
              idx_nxt   = fidx[IDX_W-1:0];
              state_nxt = S_FRD;
            end
          end
        end
      end
      S_ARD: begin
        if (idx_r >= cnt) begin
          if (exact_r) begin
            exact_nxt = 1'b0;
            idx_nxt   = '0;
          end else begin
            fin        = 1'b1;
            fin_status = ST_NO_SPACE;
            state_nxt  = S_IDLE;
          end
        end else begin
          mem_req.re   = 1'b1;
          mem_req.addr = idx_r[ADDR_W-1:0];
          state_nxt    = S_AEV;
        end
      end
      S_AEV: begin
        if (match) begin
          lg_nxt    = mem_rdata.lg;
          state_nxt = S_SPLIT;
        end else begin
          idx_nxt   = idx_r + span;
          state_nxt = S_ARD;
        end
      end
      S_SPLIT: begin
        mem_req.we         = 1'b1;
        mem_req.wdata.head = 1'b1;
        if (lg_r > n_r) begin
          // Upper half stays free
          lg_nxt           = lg_r - LOG_W'(1);
          mem_req.addr     = idx_r[ADDR_W-1:0] + (ADDR_W'(1) << (lg_nxt - m));
          mem_req.wdata.lg = lg_nxt;
        end else begin
          mem_req.addr       = idx_r[ADDR_W-1:0];
          mem_req.wdata.used = 1'b1;
          mem_req.wdata.lg   = lg_r;
          fin                = 1'b1;
          fin_off            = off_w[15:0];
          fin_lg             = lg_r;
          state_nxt          = S_IDLE;
        end
      end
      S_FRD: begin
        mem_req.re   = 1'b1;
        mem_req.addr = idx_r[ADDR_W-1:0];
        state_nxt    = S_FEV;
      end
      S_FEV: begin
        if (!mem_rdata.head || !mem_rdata.used) begin
          fin        = 1'b1;
          fin_status = ST_BAD_FREE;
          state_nxt  = S_IDLE;
        end else begin
          lg_nxt             = mem_rdata.lg;
          mem_req.we         = 1'b1;
          mem_req.addr       = idx_r[ADDR_W-1:0];
          mem_req.wdata.head = 1'b1;
          mem_req.wdata.lg   = mem_rdata.lg;
          state_nxt          = S_MCHK;
        end
      end
      S_MCHK: begin
        if (lg_r < h && lg_r >= m) begin
          mem_req.re   = 1'b1;
          mem_req.addr = bud;
          state_nxt    = S_MEV;
        end else begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_MEV: begin
        if (!mem_rdata.head || mem_rdata.used || mem_rdata.lg != lg_r) begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          // Drop the upper buddy, merged head goes to the lower one
          mem_req.we   = 1'b1;
          mem_req.addr = hi;
          idx_nxt      = IDX_W'(lo);
          lg_nxt       = lg_r + LOG_W'(1);
          state_nxt    = S_MWR;
        end
      end
      S_MWR: begin
        mem_req.we         = 1'b1;
        mem_req.addr       = idx_r[ADDR_W-1:0];
        mem_req.wdata.head = 1'b1;
        mem_req.wdata.lg   = lg_r;
        state_nxt          = S_MCHK;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_wr) begin
      state_nxt = S_CLEAR;
      clr_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      heap_r      <= LOG_W'(16);
      min_r       <= LOG_W'(6);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= fin;
      if (cfg_wr) begin
        if (cfg_index == CFG_HEAP) heap_r <= cfg_data;
        else                       min_r  <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    lg_r    <= lg_nxt;
    n_r     <= n_nxt;
    exact_r <= exact_nxt;
    if (fin) begin
      out_status_r <= fin_status;
      out_off_r    <= fin_off;
      out_lg_r     <= fin_lg;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_result_offset   = out_off_r;
  assign out_result_log_size = out_lg_r;

endmodule

// ----- hw/rtl/bba_checker.sv -----
// Port-level checks for the buddy block allocator, bound to the top level.
// Depends on bba_pkg and buddy_block_allocator_unit.
module bba_checker import bba_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_action,
  input logic [16:0] in_request_size,
  input logic [15:0] in_block_offset,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic [15:0] out_result_offset,
  input logic [4:0]  out_result_log_size,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        cfg_index,
  input logic [4:0]  cfg_data
);

  // A result follows either an accepted request or a busy cycle
  a_strobe_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start || busy)) else $error("result strobe with no request");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_result_offset == 16'd0 && out_result_log_size == 5'd0))
    else $error("error result carries payload");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_BAD_FREE && out_result_log_size <= 5'd16))
    else $error("result out of range");

  // A config write restarts the table clear
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> busy) else $error("no clear after config");

endmodule

bind buddy_block_allocator_unit bba_checker u_bba_checker (.*);

// ----- sim/bba_checker.sv -----
`timescale 1ns / 100ps
// Checker for the buddy block allocator: watches requests, config writes and results,
// keeps its own copy of the block table and compares every result. Depends on bba_pkg.
module bba_scoreboard import bba_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_action,
  input  logic [16:0] in_request_size,
  input  logic [15:0] in_block_offset,
  input  logic        out_valid,
  input  logic [2:0]  out_status,
  input  logic [15:0] out_result_offset,
  input  logic [4:0]  out_result_log_size,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  output int          fail_count,
  output int          pending_cnt
);

  typedef struct {
    status_t     status;
    logic [15:0] offset;
    logic [4:0]  log_size;
  } alloc_result_t;

  alloc_result_t expected_q[$];
  entry_t        blocks[TABLE_DEPTH];
  logic [4:0]    heap_reg, min_reg;
  int            heap_lg, min_lg;

  function automatic void clear_table();
    heap_lg = heap_reg;
    min_lg  = min_reg;
    if (heap_lg > MAX_HEAP_LOG) heap_lg = MAX_HEAP_LOG;
    if (min_lg > heap_lg) min_lg = heap_lg;
    if (heap_lg - min_lg > MAX_LEVELS) min_lg = heap_lg - MAX_LEVELS;
    for (int k = 0; k < TABLE_DEPTH; k++) blocks[k] = '0;
    blocks[0] = '{head: 1'b1, used: 1'b0, lg: LOG_W'(heap_lg)};
  endfunction

  function automatic int num_slots();
    return 1 << (heap_lg - min_lg);
  endfunction

  function automatic int slots_spanned(entry_t e);
    int lg;
    lg = e.lg;
    if (!e.head || lg < min_lg || lg - min_lg > MAX_LEVELS) return 1;
    return 1 << (lg - min_lg);
  endfunction

  // First free block in address order of size n (exact) or at least n.
  function automatic int first_free(int n, bit exact);
    int     i;
    entry_t e;
    i = 0;
    while (i < num_slots()) begin
      e = blocks[i % TABLE_DEPTH];
      if (e.head && !e.used && (exact ? (int'(e.lg) == n) : (int'(e.lg) >= n))) return i;
      i += slots_spanned(e);
    end
    return num_slots();
  endfunction

  function automatic alloc_result_t allocate(logic [16:0] size);
    alloc_result_t r;
    int            n, i, lg;
    r = '{ST_OK, 16'd0, 5'd0};
    n = 0;
    if (size == 0) begin
      r.status = ST_ZERO_SIZE;
      return r;
    end
    while (n < 31 && (1 << n) < int'(size)) n++;
    if (n < min_lg) n = min_lg;
    if (n > heap_lg) begin
      r.status = ST_TOO_BIG;
      return r;
    end
    i = first_free(n, 1'b1);
    if (i >= num_slots()) i = first_free(n, 1'b0);
    if (i >= num_slots()) begin
      r.status = ST_NO_SPACE;
      return r;
    end
    i  = i % TABLE_DEPTH;
    lg = blocks[i].lg;
    // split down, leaving each upper half free
    while (lg > n) begin
      lg--;
      blocks[(i + (1 << (lg - min_lg))) % TABLE_DEPTH] = '{1'b1, 1'b0, LOG_W'(lg)};
    end
    blocks[i]    = '{1'b1, 1'b1, LOG_W'(lg)};
    r.offset     = 16'((i << min_lg) & 32'hFFFF);
    r.log_size   = 5'(lg);
    return r;
  endfunction

  function automatic alloc_result_t release_block(logic [15:0] off);
    alloc_result_t r;
    int            i, lg, b, lo;
    entry_t        be;
    r = '{ST_BAD_FREE, 16'd0, 5'd0};
    if ((int'(off) & ((1 << min_lg) - 1)) != 0) return r;
    i = int'(off) >> min_lg;
    if (i >= num_slots()) return r;
    i = i % TABLE_DEPTH;
    if (!blocks[i].head || !blocks[i].used) return r;
    lg        = blocks[i].lg;
    blocks[i] = '{1'b1, 1'b0, LOG_W'(lg)};
    // merge with the buddy while it is a free head of equal size
    while (lg < heap_lg && lg >= min_lg) begin
      b  = (i ^ (1 << (lg - min_lg))) % TABLE_DEPTH;
      be = blocks[b];
      if (!be.head || be.used || int'(be.lg) != lg) break;
      lo = (i < b) ? i : b;
      blocks[i ^ b ^ lo] = '0;
      lg++;
      blocks[lo] = '{1'b1, 1'b0, LOG_W'(lg)};
      i = lo;
    end
    r.status = ST_OK;
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst_n) begin
      heap_reg   = 5'd16;
      min_reg    = 5'd6;
      fail_count = 0;
      expected_q.delete();
      clear_table();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_HEAP) heap_reg = cfg_data;
        else min_reg = cfg_data;
        clear_table();
      end
      if (start && !busy) begin
        if (in_action == ACT_ALLOC) want = allocate(in_request_size);
        else want = release_block(in_block_offset);
        expected_q.push_back(want);
      end
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
          if (out_result_offset != want.offset) begin
            $error("result_offset: expected %0d, got %0d", want.offset, out_result_offset);
            fail_count++;
          end
          if (out_result_log_size != want.log_size) begin
            $error("result_log_size: expected %0d, got %0d", want.log_size,
                   out_result_log_size);
            fail_count++;
          end
        end
      end
    end
    pending_cnt = expected_q.size();
  end

endmodule

// ----- sim/tb_buddy_block_allocator_unit.sv -----
`timescale 1ns / 100ps
// Testbench top for buddy_block_allocator_unit: drives requests and config writes,
// gives the verdict. Depends on bba_pkg, the block and bba_scoreboard.
module tb_buddy_block_allocator_unit import bba_pkg::*;;

  localparam int CYCLE_LIMIT = 20000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_action = ACT_ALLOC;
  logic [16:0] in_request_size = '0;
  logic [15:0] in_block_offset = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [15:0] out_result_offset;
  logic [4:0]  out_result_log_size;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_HEAP;
  logic [4:0]  cfg_data = '0;
  int          fail_count, pending_cnt;
  int          cycles = 0;
  int          cur_heap = 16;

  logic        sent_action_q[$];
  logic [15:0] live_q[$];
  logic [15:0] last_freed = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  buddy_block_allocator_unit uut (.*);

  bba_scoreboard u_checker (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("buddy_block_allocator_unit verification failed");
      $finish;
    end
  end

  // remember granted blocks so that later frees can hit them
  always @(posedge clk) begin
    logic act;
    if (rst_n && out_valid && sent_action_q.size() > 0) begin
      act = sent_action_q.pop_front();
      if (act == ACT_ALLOC && out_status == ST_OK) live_q.push_back(out_result_offset);
    end
  end

  task automatic send_request(logic act, logic [16:0] size, logic [15:0] off, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start           <= 1'b1;
    in_action       <= act;
    in_request_size <= size;
    in_block_offset <= off;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sent_action_q.push_back(act);
  endtask

  task automatic write_reg(logic idx, logic [4:0] val);
    @(negedge clk);
    start <= 1'b0;
    while (pending_cnt != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    live_q.delete();
    if (idx == CFG_HEAP) cur_heap = (val > MAX_HEAP_LOG) ? MAX_HEAP_LOG : val;
  endtask

  task automatic alloc(logic [16:0] size, int idle_pct = 0);
    send_request(ACT_ALLOC, size, 16'($urandom_range(16'hFFFF)), idle_pct);
  endtask

  task automatic free(logic [15:0] off, int idle_pct = 0);
    send_request(ACT_FREE, 17'(off), off, idle_pct);
  endtask

  task automatic random_phase(int count, int idle_pct);
    int          pick, sel;
    logic [15:0] off;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        alloc(17'($urandom_range((1 << cur_heap) / 2 + 1, 1)), idle_pct);
      end else if (sel < 50) begin
        alloc(17'($urandom_range(17'h10000)), idle_pct);
      end else if (sel < 52) begin
        alloc('0, idle_pct);
      end else if (sel < 85 && live_q.size() > 0) begin
        pick = $urandom_range(live_q.size() - 1);
        off  = live_q[pick];
        live_q.delete(pick);
        last_freed = off;
        free(off, idle_pct);
      end else if (sel < 90) begin
        free(last_freed, idle_pct);
      end else begin
        free(16'($urandom_range(16'hFFFF)), idle_pct);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset setting, 1024 slots of 64 bytes
    alloc('0);
    alloc(17'h10000);
    alloc(17'd1);
    free(16'd0);
    free(16'd0);
    free(16'd1);
    alloc(17'd1);
    alloc(17'd100);
    alloc(17'd64);
    alloc(17'd64);
    free(16'd128);
    free(16'd64);
    free(16'hFFFF);
    free(16'd0);
    free(16'd192);
    alloc(17'd32768);
    alloc(17'd32769);
    free(16'd32768);
    free(16'd0);

    // extremes of both registers
    write_reg(CFG_HEAP, 5'd31);
    write_reg(CFG_MIN, 5'd31);
    alloc(17'd1);
    alloc(17'd1);
    write_reg(CFG_MIN, 5'd0);
    alloc(17'd1);
    free(16'd0);
    write_reg(CFG_HEAP, 5'd0);
    alloc(17'd1);
    alloc(17'd2);
    free(16'd1);
    free(16'd0);
    write_reg(CFG_HEAP, 5'd10);
    write_reg(CFG_MIN, 5'd4);
    free(16'hFC00);
    alloc(17'd2000);

    // random phases, small tables to keep scans short
    random_phase(140, 0);
    write_reg(CFG_HEAP, 5'd8);
    write_reg(CFG_MIN, 5'd5);
    random_phase(150, 79);
    write_reg(CFG_HEAP, 5'd12);
    write_reg(CFG_MIN, 5'd6);
    random_phase(140, 0);
    write_reg(CFG_HEAP, 5'd16);
    write_reg(CFG_MIN, 5'd12);
    random_phase(150, 26);

    @(negedge clk);
    start <= 1'b0;
    while (pending_cnt != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("buddy_block_allocator_unit verification clean");
    end else begin
      $display("buddy_block_allocator_unit verification failed");
    end
    $finish;
  end

endmodule
